### hw/rtl/afp_pkg.sv
// ----------------------------------------------------------------------------
// afp_pkg: shared types and constants for the animation frame position block
// Field widths, fixed-point formats, mode and register codes, and the item
// record that travels through the remainder pipeline.
// ----------------------------------------------------------------------------
package afp_pkg;

    // port field widths
    localparam int TimeW   = 32;
    localparam int RateW   = 16;
    localparam int ModeW   = 3;
    localparam int PosW    = 32;
    localparam int FcW     = 16;
    localparam int FpsW    = 10;
    localparam int CfgIdxW = 1;

    // internal fixed-point formats
    localparam int TrW     = (TimeW - 1) + (RateW - 1);   // time * rate, Q.24
    localparam int ProdW   = TrW + FpsW;                  // time * rate * fps
    localparam int FracW   = 24;                          // fraction bits of the product
    localparam int IntW    = ProdW - FracW;               // integer frames
    localparam int PosInW  = FcW + FracW;                 // position before truncation
    localparam int DropW   = FracW - 16;                  // bits dropped to reach Q16.16

    // remainder pipeline: quotient bits resolved per stage
    localparam int DivStepBits = 4;
    localparam int DivStages   = IntW / DivStepBits;

    localparam logic [FpsW-1:0] FpsReset = 10'd30;

    // playback modes
    localparam logic [ModeW-1:0] MODE_MANUAL    = 3'd0;
    localparam logic [ModeW-1:0] MODE_ONCE      = 3'd1;
    localparam logic [ModeW-1:0] MODE_LOOP      = 3'd2;
    localparam logic [ModeW-1:0] MODE_PINGPONG  = 3'd3;
    localparam logic [ModeW-1:0] MODE_LOOP_BACK = 3'd4;
    localparam logic [ModeW-1:0] MODE_ONCE_BACK = 3'd5;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_FRAME_COUNT = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_FPS         = 1'd1;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [IntW-1:0]  fi;
        logic [FracW-1:0] frac;
    } t_item;

endpackage

### hw/rtl/afp_rem_pipe.sv
// ----------------------------------------------------------------------------
// afp_rem_pipe: pipelined integer remainder
// Restoring division of the integer frame count by the last frame index,
// a few quotient bits per stage. Returns the remainder and the quotient LSB.
// ----------------------------------------------------------------------------
module afp_rem_pipe (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  afp_pkg::t_item        i_item,
    input  logic [afp_pkg::FcW-1:0] i_divisor,
    output logic                  o_valid,
    input  logic                  i_ready,
    output afp_pkg::t_item        o_item,
    output logic [afp_pkg::FcW-1:0] o_rem,
    output logic                  o_q0
);

    localparam int NStg = afp_pkg::DivStages;
    localparam int RemW = afp_pkg::FcW;

    logic [NStg-1:0] r_v;
    afp_pkg::t_item  r_item [NStg];
    logic [RemW-1:0] r_rem  [NStg];
    logic [NStg-1:0] r_q0;
    logic [NStg:0]   w_en;

    assign w_en[NStg] = i_ready;
    assign o_ready    = w_en[0];

    for (genvar s = 0; s < NStg; s++) begin : g_stage
        afp_pkg::t_item  w_item;
        logic [RemW-1:0] w_rem_in;
        logic            w_v_in;
        logic [RemW-1:0] n_rem;
        logic            n_q0;

        // a stage moves on when it is empty or the next one moves
        assign w_en[s] = !r_v[s] || w_en[s+1];

        if (s == 0) begin : g_first
            assign w_item   = i_item;
            assign w_rem_in = '0;
            assign w_v_in   = i_valid;
        end else begin : g_next
            assign w_item   = r_item[s-1];
            assign w_rem_in = r_rem[s-1];
            assign w_v_in   = r_v[s-1];
        end

        always_comb begin : p_step
            logic [RemW:0]   w_tmp;
            logic [RemW-1:0] w_rem;
            w_rem = w_rem_in;
            n_q0  = 1'b0;
            for (int k = 0; k < afp_pkg::DivStepBits; k++) begin
                w_tmp = {w_rem, w_item.fi[afp_pkg::IntW-1-s*afp_pkg::DivStepBits-k]};
                if (w_tmp >= {1'b0, i_divisor}) begin
                    w_tmp = w_tmp - {1'b0, i_divisor};
                    n_q0  = 1'b1;
                end else begin
                    n_q0  = 1'b0;
                end
                w_rem = w_tmp[RemW-1:0];
            end
            n_rem = w_rem;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_en[s]) begin
                r_v[s] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[s] && w_v_in) begin
                r_item[s] <= w_item;
                r_rem[s]  <= n_rem;
                r_q0[s]   <= n_q0;
            end
        end
    end

    assign o_valid = r_v[NStg-1];
    assign o_item  = r_item[NStg-1];
    assign o_rem   = r_rem[NStg-1];
    assign o_q0    = r_q0[NStg-1];

endmodule

### hw/rtl/animation_frame_position.sv
// ----------------------------------------------------------------------------
// animation_frame_position: playback time to fractional frame position
// Scales a Q16.16 time by a Q8.8 rate and the clip frame rate, then clamps,
// wraps, ping-pongs or reverses it against the last frame index.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle when no stall holds the input. One
// stage forms time times rate, one multiplies by the frame rate, eight
// stages of the remainder pipeline divide the integer part of the product
// by the last frame index (four quotient bits a stage), one stage folds the
// remainder for ping-pong and one selects the mode result into the output
// register. Stalls hold each stage in place; empty stages still fill while
// the output waits. Write frame_count and frames_per_second only while no
// request is in flight. There is no clearing pass after reset.
module animation_frame_position (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [afp_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [afp_pkg::FcW-1:0]        i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [afp_pkg::TimeW-1:0] i_elapsed_time,
    input  logic signed [afp_pkg::RateW-1:0] i_play_rate,
    input  logic [afp_pkg::ModeW-1:0]      i_mode,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [afp_pkg::PosW-1:0]       o_frame_position,
    output logic                           o_finished
);

    localparam int TW = afp_pkg::TimeW;
    localparam int RW = afp_pkg::RateW;
    localparam int FW = afp_pkg::FracW;
    localparam int CW = afp_pkg::FcW;
    localparam int PW = afp_pkg::PosInW;

    // configuration
    logic [CW-1:0]            r_frame_count;
    logic [afp_pkg::FpsW-1:0] r_fps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_fps         <= afp_pkg::FpsReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                afp_pkg::REG_FRAME_COUNT: r_frame_count <= i_cfg_wdata;
                afp_pkg::REG_FPS:         r_fps <= i_cfg_wdata[afp_pkg::FpsW-1:0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0] w_d;      // last frame index
    logic          w_active;
    assign w_d      = r_frame_count - CW'(1);
    assign w_active = (r_frame_count[CW-1:1] != '0) && (r_fps != '0);

    // stage control
    logic w_en_a, w_en_b, w_en_c, w_en_o, w_div_ready;

    // stage a: clamp and time * rate
    logic                      r_a_v;
    logic [afp_pkg::TrW-1:0]   r_a_tr;
    logic [afp_pkg::ModeW-1:0] r_a_mode;
    logic [TW-2:0]             w_t;
    logic [RW-2:0]             w_r;
    logic [afp_pkg::TrW-1:0]   n_a_tr;

    assign w_t    = i_elapsed_time[TW-1] ? '0 : i_elapsed_time[TW-2:0];
    assign w_r    = i_play_rate[RW-1] ? '0 : i_play_rate[RW-2:0];
    assign n_a_tr = w_t * w_r;
    assign w_en_a = !r_a_v || w_en_b;
    assign o_ready = w_en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en_a) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a && i_valid) begin
            r_a_tr   <= n_a_tr;
            r_a_mode <= i_mode;
        end
    end

    // stage b: times frame rate
    logic                      r_b_v;
    logic [afp_pkg::ProdW-1:0] r_b_prod;
    logic [afp_pkg::ModeW-1:0] r_b_mode;
    logic [afp_pkg::ProdW-1:0] n_b_prod;
    afp_pkg::t_item            w_b_item;

    assign n_b_prod = r_a_tr * r_fps;
    assign w_en_b   = !r_b_v || w_div_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en_b) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_b && r_a_v) begin
            r_b_prod <= n_b_prod;
            r_b_mode <= r_a_mode;
        end
    end

    assign w_b_item.mode = r_b_mode;
    assign w_b_item.fi   = r_b_prod[afp_pkg::ProdW-1:FW];
    assign w_b_item.frac = r_b_prod[FW-1:0];

    // remainder of the integer frames by the last frame index
    logic           w_div_v;
    afp_pkg::t_item w_div_item;
    logic [CW-1:0]  w_div_rem;
    logic           w_div_q0;

    afp_rem_pipe u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_b_v),
        .o_ready   (w_div_ready),
        .i_item    (w_b_item),
        .i_divisor (w_d),
        .o_valid   (w_div_v),
        .i_ready   (w_en_c),
        .o_item    (w_div_item),
        .o_rem     (w_div_rem),
        .o_q0      (w_div_q0)
    );

    // stage c: compare against the end and fold for ping-pong
    logic                      r_c_v;
    logic [afp_pkg::ModeW-1:0] r_c_mode;
    logic [FW-1:0]             r_c_frac;
    logic [CW-1:0]             r_c_fil;
    logic [CW-1:0]             r_c_rem;
    logic [CW:0]               r_c_pi;
    logic                      r_c_ge;
    logic                      r_c_pup;
    logic                      n_c_ge;
    logic [CW:0]               n_c_pi;
    logic                      n_c_pup;

    // product at or past the end frame
    assign n_c_ge = w_div_item.fi >= {{(afp_pkg::IntW-CW){1'b0}}, w_d};
    // remainder modulo twice the end: add the end back on odd quotients
    assign n_c_pi = {1'b0, w_div_rem} + (w_div_q0 ? {1'b0, w_d} : '0);
    assign n_c_pup = (n_c_pi < {1'b0, w_d})
                  || ((n_c_pi == {1'b0, w_d}) && (w_div_item.frac == '0));
    assign w_en_c = !r_c_v || w_en_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en_c) begin
            r_c_v <= w_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_c && w_div_v) begin
            r_c_mode <= w_div_item.mode;
            r_c_frac <= w_div_item.frac;
            r_c_fil  <= w_div_item.fi[CW-1:0];
            r_c_rem  <= w_div_rem;
            r_c_pi   <= n_c_pi;
            r_c_ge   <= n_c_ge;
            r_c_pup  <= n_c_pup;
        end
    end

    // output stage: pick the mode result
    logic                r_out_valid;
    logic [afp_pkg::PosW-1:0] r_pos;
    logic                r_fin;
    logic [PW-1:0]       w_e;
    logic [PW:0]         w_e2;
    logic [PW:0]         w_pp_down;
    logic [PW-1:0]       w_loop_back;
    logic [PW-1:0]       w_once_back;
    logic [PW-1:0]       n_pos;
    logic                n_fin;

    assign w_e         = {w_d, {FW{1'b0}}};
    assign w_e2        = {w_d, 1'b0, {FW{1'b0}}};
    assign w_pp_down   = w_e2 - {r_c_pi, r_c_frac};
    assign w_loop_back = w_e - {r_c_rem, r_c_frac};
    assign w_once_back = w_e - {r_c_fil, r_c_frac};
    assign w_en_o      = !r_out_valid || i_ready;

    always_comb begin
        n_pos = '0;
        n_fin = 1'b0;
        case (r_c_mode)
            afp_pkg::MODE_MANUAL:    n_pos = r_c_ge ? w_e : {r_c_fil, r_c_frac};
            afp_pkg::MODE_ONCE: begin
                n_pos = r_c_ge ? w_e : {r_c_fil, r_c_frac};
                n_fin = (r_frame_count == '0) || (r_fps == '0) || r_c_ge;
            end
            afp_pkg::MODE_LOOP:      n_pos = {r_c_rem, r_c_frac};
            afp_pkg::MODE_PINGPONG:  n_pos = r_c_pup ? {r_c_pi[CW-1:0], r_c_frac}
                                                     : w_pp_down[PW-1:0];
            afp_pkg::MODE_LOOP_BACK: n_pos = w_loop_back;
            afp_pkg::MODE_ONCE_BACK: begin
                n_pos = r_c_ge ? '0 : w_once_back;
                n_fin = (r_frame_count == '0) || (r_fps == '0) || r_c_ge;
            end
            default: ;
        endcase
        // short clip or zero frame rate: hold the first frame
        if (!w_active) begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_o) begin
            r_out_valid <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_o && r_c_v) begin
            r_pos <= n_pos[PW-1:afp_pkg::DropW];
            r_fin <= n_fin;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_position = r_pos;
    assign o_finished       = r_fin;

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for animation_frame_position
// Sends playback requests under several clip settings and idling patterns and
// compares every result with an in-bench prediction of the clamp, wrap,
// ping-pong and reverse mapping, field by field, in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import afp_pkg::*;

    localparam int PIPE_LATENCY    = 12;
    localparam int HOLD_CYCLES     = 120;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int CLIPS_PER_PHASE = 3;
    localparam int ITEMS_PER_CLIP  = 100;

    // mode codes that carry no meaning in the block
    localparam logic [ModeW-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [ModeW-1:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [PosW-1:0] pos;
        logic            fin;
    } t_frame_result;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_cfg_we       = 1'b0;
    logic [CfgIdxW-1:0]       i_cfg_idx      = REG_FRAME_COUNT;
    logic [FcW-1:0]           i_cfg_wdata    = '0;
    logic                     i_valid        = 1'b0;
    logic signed [TimeW-1:0]  i_elapsed_time = '0;
    logic signed [RateW-1:0]  i_play_rate    = '0;
    logic [ModeW-1:0]         i_mode         = MODE_MANUAL;
    logic                     i_ready        = 1'b0;
    logic                     o_ready;
    logic                     o_valid;
    logic [PosW-1:0]          o_frame_position;
    logic                     o_finished;

    // predictor copy of the clip registers
    logic [FcW-1:0]           clip_frames = '0;
    logic [FpsW-1:0]          clip_fps    = FpsReset;

    t_frame_result            expected_positions[$];
    int unsigned              requests_sent   = 0;
    int unsigned              results_checked = 0;
    int unsigned              mismatches      = 0;
    int unsigned              clips_loaded    = 0;
    int unsigned              cycle_count     = 0;
    int                       source_idle_pct = 0;
    int                       sink_stall_pct  = 0;
    int                       hold_left       = 0;
    bit                       hold_request    = 1'b0;

    animation_frame_position DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_elapsed_time   (i_elapsed_time),
        .i_play_rate      (i_play_rate),
        .i_mode           (i_mode),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_frame_position (o_frame_position),
        .o_finished       (o_finished)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles", $time, cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin : sink_drive
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    function automatic t_frame_result predict_frame_position(
        input logic signed [TimeW-1:0] elapsed,
        input logic signed [RateW-1:0] rate,
        input logic [ModeW-1:0]        mode
    );
        logic [63:0]    t_pos, r_pos, product, last_frame, span2, folded, position;
        logic [FcW-1:0] last_index;
        t_frame_result  res;
        t_pos      = elapsed[TimeW-1] ? 64'd0 : 64'(elapsed[TimeW-2:0]);
        r_pos      = rate[RateW-1] ? 64'd0 : 64'(rate[RateW-2:0]);
        product    = t_pos * r_pos * 64'(clip_fps);
        last_index = clip_frames - 1'b1;
        last_frame = 64'(last_index) << FracW;
        span2      = last_frame << 1;
        position   = 64'd0;
        res.fin    = 1'b0;
        if (mode == MODE_ONCE || mode == MODE_ONCE_BACK)
            res.fin = (clip_frames == 0 || clip_fps == 0) ? 1'b1 : (product >= last_frame);
        if (clip_frames >= 2 && clip_fps != 0) begin
            case (mode)
                MODE_MANUAL, MODE_ONCE: begin
                    position = (product < last_frame) ? product : last_frame;
                end
                MODE_LOOP: begin
                    position = product % last_frame;
                end
                MODE_PINGPONG: begin
                    folded   = product % span2;
                    position = (folded <= last_frame) ? folded : span2 - folded;
                end
                MODE_LOOP_BACK: begin
                    position = last_frame - (product % last_frame);
                end
                MODE_ONCE_BACK: begin
                    position = (product < last_frame) ? last_frame - product : 64'd0;
                end
                default: begin
                    position = 64'd0;
                end
            endcase
        end
        res.pos = position[DropW +: PosW];
        return res;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_positions.size() == 0) begin
                $display("%0t: result with none pending, got pos=%h fin=%b",
                         $time, o_frame_position, o_finished);
                mismatches++;
            end else begin
                want = expected_positions.pop_front();
                results_checked++;
                if (o_frame_position !== want.pos) begin
                    $display("%0t: frame_position expected %h got %h",
                             $time, want.pos, o_frame_position);
                    mismatches++;
                end
                if (o_finished !== want.fin) begin
                    $display("%0t: finished expected %b got %b",
                             $time, want.fin, o_finished);
                    mismatches++;
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(
        input logic signed [TimeW-1:0] elapsed,
        input logic signed [RateW-1:0] rate,
        input logic [ModeW-1:0]        mode
    );
        while ($urandom_range(0, 99) < source_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_elapsed_time = elapsed;
        i_play_rate    = rate;
        i_mode         = mode;
        do @(posedge i_clk); while (!o_ready);
        expected_positions.insert(expected_positions.size(),
                                  predict_frame_position(elapsed, rate, mode));
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_valid = 1'b0;
        while (expected_positions.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [FcW-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        @(posedge i_clk);
        if (idx == REG_FRAME_COUNT)
            clip_frames = data;
        else
            clip_fps = data[FpsW-1:0];
        @(negedge i_clk);
    endtask

    task automatic load_clip(input logic [FcW-1:0] frames, input logic [FcW-1:0] fps_word);
        wait_for_drain();
        write_register(REG_FRAME_COUNT, frames);
        write_register(REG_FPS, fps_word);
        i_cfg_we = 1'b0;
        clips_loaded++;
    endtask

    task automatic load_random_clip();
        logic [FcW-1:0] frames;
        logic [FcW-1:0] fps_word;
        case ($urandom_range(0, 15))
            0, 1:    frames = 16'hFFFF;
            2, 3:    frames = 16'd2;
            4:       frames = 16'($urandom_range(0, 1));
            5, 6, 7: frames = 16'($urandom_range(3, 64));
            default: frames = 16'($urandom);
        endcase
        // upper bits of the rate word must be ignored by the register
        fps_word = 16'($urandom);
        case ($urandom_range(0, 15))
            0, 1:    fps_word[FpsW-1:0] = '1;
            2, 3:    fps_word[FpsW-1:0] = 10'd1;
            4:       fps_word[FpsW-1:0] = '0;
            5, 6:    fps_word[FpsW-1:0] = 10'($urandom);
            default: fps_word[FpsW-1:0] = 10'($urandom_range(1, 120));
        endcase
        load_clip(frames, fps_word);
    endtask

    // most requests land within three clip lengths, so every wrap and fold is hit
    task automatic send_random_request();
        logic [63:0]             last_whole, span, aligned;
        logic [63:0]             fps_div, rate_div;
        logic signed [TimeW-1:0] elapsed;
        logic signed [RateW-1:0] rate;
        logic [ModeW-1:0]        mode;
        int unsigned             kind;
        last_whole = (clip_frames >= 2) ? 64'(clip_frames - 16'd1) : 64'd30;
        fps_div    = (clip_fps == 0) ? 64'd1 : 64'(clip_fps);
        kind       = $urandom_range(0, 9);
        if (kind < 2) begin
            elapsed = $urandom;
            rate    = 16'($urandom);
        end else if (kind < 9) begin
            rate     = 16'($urandom_range(0, 16'h0200));
            rate_div = (rate == 0) ? 64'd1 : 64'(rate);
            span     = ((last_whole * 3) << FracW) / (rate_div * fps_div);
            if (span > 64'h7FFF_FFFF)
                span = 64'h7FFF_FFFF;
            elapsed = $urandom_range(0, 32'(span));
        end else begin
            // land on or right beside a whole number of clip lengths
            rate    = 16'sh0100;
            aligned = ((64'($urandom_range(1, 4)) * last_whole) << 16) / fps_div;
            if (aligned > 64'h7FFF_FFF0)
                aligned = 64'h7FFF_FFF0;
            aligned = aligned + $urandom_range(0, 2);
            elapsed = 32'(aligned) - 32'sd1;
        end
        if ($urandom_range(0, 15) == 0)
            mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE_6 : MODE_SPARE_7;
        else
            mode = 3'($urandom_range(0, 5));
        send_request(elapsed, rate, mode);
    endtask

    task automatic test_reset_defaults();
        // no clip written yet: zero frames at the default frame rate
        send_request(32'sh0001_0000, 16'sh0100, MODE_ONCE);
        send_request(32'sh0001_0000, 16'sh0100, MODE_MANUAL);
    endtask

    task automatic test_field_extremes();
        load_clip(16'hFFFF, 16'd1023);
        send_request(32'sh7FFF_FFFF, 16'sh7FFF, MODE_LOOP);
        send_request(32'sh8000_0000, 16'sh8000, MODE_ONCE);
        send_request(32'shFFFF_FFFF, 16'sh7FFF, MODE_PINGPONG);
        send_request(32'sh7FFF_FFFF, 16'shFFFF, MODE_ONCE_BACK);
        send_request(32'sh7FFF_FFFF, 16'sh7FFF, MODE_MANUAL);
        send_request(32'sh7FFF_FFFF, 16'sh7FFF, MODE_ONCE);
    endtask

    task automatic test_frame_boundaries();
        // 31 frames at 30 fps: one second at unit rate is exactly the last frame
        load_clip(16'd31, 16'd30);
        send_request(32'sh0001_0000, 16'sh0100, MODE_ONCE);
        send_request(32'sh0001_0000, 16'sh0100, MODE_LOOP);
        send_request(32'sh0001_0000, 16'sh0100, MODE_LOOP_BACK);
        send_request(32'sh0001_0000, 16'sh0100, MODE_PINGPONG);
        send_request(32'sh0002_0000, 16'sh0100, MODE_PINGPONG);
        send_request(32'sh0001_0000, 16'sh0100, MODE_ONCE_BACK);
        send_request(32'sh0000_FFFF, 16'sh0100, MODE_ONCE);
        send_request(32'sh0000_8000, 16'sh0100, MODE_ONCE_BACK);
    endtask

    task automatic test_short_clip_and_zero_rate();
        load_clip(16'd1, 16'd30);
        send_request(32'sh0001_0000, 16'sh0100, MODE_ONCE);
        send_request(32'sh0003_0000, 16'sh0100, MODE_LOOP);
        // frame rate field zero with the ignored upper bits set
        load_clip(16'd5, 16'hFC00);
        send_request(32'sh0001_0000, 16'sh0100, MODE_ONCE);
        send_request(32'sh0001_0000, 16'sh0100, MODE_MANUAL);
    endtask

    task automatic test_unused_modes();
        load_clip(16'd31, 16'd30);
        send_request(32'sh0001_8000, 16'sh0180, MODE_SPARE_6);
        send_request(32'sh0001_8000, 16'sh0180, MODE_SPARE_7);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        source_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        for (int c = 0; c < CLIPS_PER_PHASE; c++) begin
            load_random_clip();
            repeat (ITEMS_PER_CLIP) send_random_request();
        end
    endtask

    task automatic test_backpressure();
        source_idle_pct = 0;
        sink_stall_pct  = 0;
        load_clip(16'd100, 16'd60);
        // hold the result side while requests keep coming, so the input stalls
        @(posedge i_clk);
        hold_request = 1'b1;
        @(negedge i_clk);
        repeat (60) send_random_request();
        // pause the sender until every pending result is back
        wait_for_drain();
        repeat (20) send_random_request();
    endtask

    initial begin : run_tests
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_frame_boundaries();
        test_short_clip_and_zero_rate();
        test_unused_modes();
        test_random_traffic(0, 0);
        test_random_traffic(55, 0);
        test_random_traffic(0, 55);
        test_random_traffic(34, 34);
        test_backpressure();
        wait_for_drain();

        $display("Checked %0d results from %0d requests across %0d clip settings,",
                 results_checked, requests_sent, clips_loaded);
        $display("with four idling patterns and a long result-side hold-off.");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/afp_pkg.sv
hw/rtl/afp_rem_pipe.sv
hw/rtl/animation_frame_position.sv
tb/sv/tb_top.sv
